// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define SRE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/sre_pkg.sv =====
// Shared constants, op codes and divider status type for the radix digit emitter.
// No dependencies.
package sre_pkg;

    localparam int COUNT_W = 7;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 6;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CODE_LOW   = 8'd32;
    localparam logic [CHAR_W-1:0] CODE_HIGH  = 8'd126;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    typedef struct packed {
        logic done;
        logic zero;
    } t_div_stat;

endpackage

// ===== sv/sre_alpha_mem.sv =====
// Alphabet symbol memory: one write port, one read port with registered data.
// Depends on sre_pkg.
module sre_alpha_mem
    import sre_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [CHAR_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [CHAR_W-1:0] o_rd_data
);

    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/sre_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, remainder is the digit.
// Depends on sre_pkg.
module sre_div
    import sre_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int DIGIT_W    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [COUNT_W-1:0]    i_divisor,
    output t_div_stat             o_stat,
    output logic [VALUE_BITS-1:0] o_quot,
    output logic [DIGIT_W-1:0]    o_digit
);

    localparam int CW = $clog2(VALUE_BITS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [VALUE_BITS-1:0] r_dvd;
    logic [COUNT_W-1:0]    r_rem;
    logic                  r_any;

    logic [COUNT_W:0]      trial;
    logic [COUNT_W:0]      diff;
    logic                  ge;

    always_comb begin
        trial = {r_rem, r_dvd[VALUE_BITS-1]};
        ge    = trial >= {1'b0, i_divisor};
        diff  = trial - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VALUE_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_any <= 1'b0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[VALUE_BITS-2:0], ge};
            r_rem <= ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            r_any <= r_any | ge;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.zero = !r_any;
    assign o_quot      = r_dvd;
    assign o_digit     = r_rem[DIGIT_W-1:0];

endmodule

// ===== sv/signed_radix_digit_emitter.sv =====
// Sequence: each alphabet symbol is validated in S_SCAN_RD then S_SCAN_CHK; each digit comes
// from the serial divider (S_DIV_GO, S_DIV_WAIT); each digit character then passes S_EMIT_RD,
// S_EMIT_LD and S_HOLD, a minus sign only S_HOLD, and S_HOLD waits while the output stalls.
// Throughput: one item at a time; o_in_stall holds new input off outside S_IDLE.
// Reset: synchronous active-low i_rst_n clears control state and symbol_count;
// the alphabet holds no defined content until written.
module signed_radix_digit_emitter
    import sre_pkg::*;
#(
    parameter int MAX_SYMBOLS = 64,
    parameter int VALUE_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [COUNT_W-1:0]    i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  logic [INDEX_W-1:0]    i_symbol_index,
    input  logic [CHAR_W-1:0]     i_symbol_code,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CHAR_W-1:0]     o_out_char,
    output logic                  o_out_last
);

    localparam int AW = $clog2(MAX_SYMBOLS);
    localparam int BW = $clog2(VALUE_BITS);
    localparam int NW = $clog2(VALUE_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT_RD,
        S_EMIT_LD,
        S_HOLD
    } t_state;

    t_state                r_state;
    logic [COUNT_W-1:0]    r_count;
    logic [AW-1:0]         r_idx;
    logic [NW-1:0]         r_nd;
    logic [NW-1:0]         r_k;
    logic                  r_neg;
    logic                  r_out_valid;
    logic                  r_out_last;
    logic [CHAR_W-1:0]     r_out_char;
    logic [VALUE_BITS-1:0] r_mag;
    logic [127:0]          r_seen;
    logic [AW-1:0]         r_buf [VALUE_BITS];

    logic                  in_accept;
    logic                  is_convert;
    logic                  count_bad;
    logic                  wr_en;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [CHAR_W-1:0]     rd_data;
    logic                  sym_bad;
    logic                  scan_last;
    logic [NW-1:0]         k_m1;
    logic                  div_start;
    t_div_stat             div_stat;
    logic [VALUE_BITS-1:0] div_quot;
    logic [AW-1:0]         div_digit;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign is_convert = (i_op == OP_CONVERT);
    assign count_bad  = (r_count < COUNT_W'(2)) || (r_count > COUNT_W'(MAX_SYMBOLS));
    assign wr_en      = in_accept && (i_op == OP_LOAD) && (32'(i_symbol_index) < MAX_SYMBOLS);
    assign k_m1       = r_k - NW'(1);
    assign div_start  = (r_state == S_DIV_GO);
    assign scan_last  = (COUNT_W'(r_idx) == r_count - COUNT_W'(1));

    always_comb begin
        sym_bad = (rd_data == CHAR_PLUS) || (rd_data == CHAR_MINUS) ||
                  (rd_data <= CODE_LOW) || (rd_data > CODE_HIGH) || r_seen[rd_data[6:0]];
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx;
        case (r_state)
            S_SCAN_RD: begin
                rd_en = 1'b1;
            end
            S_EMIT_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_buf[k_m1[BW-1:0]];
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    sre_alpha_mem #(
        .DEPTH (MAX_SYMBOLS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_symbol_index)),
        .i_wr_data (i_symbol_code),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sre_div #(
        .VALUE_BITS (VALUE_BITS),
        .DIGIT_W    (AW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_mag),
        .i_divisor  (r_count),
        .o_stat     (div_stat),
        .o_quot     (div_quot),
        .o_digit    (div_digit)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_nd        <= '0;
            r_k         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept && is_convert && !count_bad) begin
                        r_idx   <= '0;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (sym_bad) begin
                        r_state <= S_IDLE;
                    end else if (scan_last) begin
                        r_nd    <= '0;
                        r_state <= S_DIV_GO;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_SCAN_RD;
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_stat.done) begin
                        r_nd <= r_nd + NW'(1);
                        if (div_stat.zero) begin
                            r_k <= r_nd + NW'(1);
                            if (r_neg) begin
                                r_out_valid <= 1'b1;
                                r_state     <= S_HOLD;
                            end else begin
                                r_state <= S_EMIT_RD;
                            end
                        end else begin
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    r_k         <= k_m1;
                    r_out_valid <= 1'b1;
                    r_state     <= S_HOLD;
                end
                S_HOLD: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        r_state     <= r_out_last ? S_IDLE : S_EMIT_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_accept && is_convert) begin
            r_neg  <= i_value[VALUE_BITS-1];
            r_mag  <= i_value[VALUE_BITS-1] ? VALUE_BITS'(~i_value + 1'b1) : i_value;
            r_seen <= '0;
        end
        if (r_state == S_SCAN_CHK && !sym_bad) begin
            r_seen[rd_data[6:0]] <= 1'b1;
        end
        if (r_state == S_DIV_WAIT && div_stat.done) begin
            r_buf[r_nd[BW-1:0]] <= div_digit;
            r_mag               <= div_quot;
            if (div_stat.zero) begin
                r_out_char <= CHAR_MINUS;
                r_out_last <= 1'b0;
            end
        end
        if (r_state == S_EMIT_LD) begin
            r_out_char <= rd_data;
            r_out_last <= (r_k == NW'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

// ===== sv/sre_checker.sv =====
// Port-level checker for signed_radix_digit_emitter, attached by bind.
// Depends on sre_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sre_checker
    import sre_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              i_op,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [CHAR_W-1:0] o_out_char,
    input logic              o_out_last
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    `SRE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_char) && $stable(o_out_last))
    `SRE_ASSERT_IMP(a_busy_while_out, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `SRE_ASSERT_NXT(a_load_silent, i_clk, i_rst_n, in_acc && (i_op == OP_LOAD), !o_out_valid && !o_in_stall)
    `SRE_ASSERT_IMP(a_no_plus, i_clk, i_rst_n, o_out_valid, o_out_char != CHAR_PLUS)

endmodule

bind signed_radix_digit_emitter sre_checker u_sre_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_op        (i_op),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_char  (o_out_char),
    .o_out_last  (o_out_last)
);
